// ===== design/tlbl_pkg.sv =====
// shared types and constants for the process-tagged lru tlb
// used by tlbl_cell and tlb_lru_process_tagged; no dependencies
package tlbl_pkg;

    localparam int PAGE_W = 28;
    localparam int PID_W  = 4;
    localparam int ADDR_W = 32;
    localparam int CNT_W  = 9;
    localparam int OP_W   = 2;
    localparam int SHIFT_W = 5;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W  = 9;

    localparam int MAX_ENTRIES_DEF = 256;
    localparam int MAX_PROCESSES   = 16;

    localparam logic [SHIFT_W-1:0] SHIFT_MIN = 5'd4;
    localparam logic [SHIFT_W-1:0] SHIFT_MAX = 5'd16;
    localparam logic [CNT_W-1:0]   CAP_MIN   = 9'd8;

    localparam logic [SHIFT_W-1:0] PAGE_SHIFT_RST = 5'd12;
    localparam logic [CNT_W-1:0]   ENTRIES_RST    = 9'd256;

    localparam logic [OP_W-1:0] OP_LOOKUP = 2'd0;
    localparam logic [OP_W-1:0] OP_SWITCH = 2'd1;
    localparam logic [OP_W-1:0] OP_EXIT   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_PAGE_SHIFT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ENTRIES    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FLUSH      = 2'd2;

    typedef struct packed {
        logic [PAGE_W-1:0] page;
        logic [PID_W-1:0]  pid;
    } entry_t;

    typedef enum logic [2:0] {
        CMD_HOLD,
        CMD_FLUSH,
        CMD_MARK,
        CMD_SHIFT,
        CMD_PUSH
    } cell_cmd_t;

    typedef struct packed {
        cell_cmd_t         cmd;
        logic [PAGE_W-1:0] page;
        logic [PID_W-1:0]  pid;
        logic              match_page;
        logic              trim;
        logic [CNT_W-1:0]  cap_m1;
    } cell_ctl_t;

endpackage

// ===== design/tlbl_cell.sv =====
// one tlb position of the recency chain: entry, valid bit and removal mark
// depends on tlbl_pkg
module tlbl_cell #(
    parameter int POS = 0
) (
    input  logic               clk,
    input  logic               rst_n,
    input  tlbl_pkg::cell_ctl_t ctl,
    input  tlbl_pkg::entry_t   prev_entry,
    input  logic               prev_valid,
    input  tlbl_pkg::entry_t   next_entry,
    input  logic               next_valid,
    input  logic               next_mark,
    output tlbl_pkg::entry_t   entry,
    output logic               valid,
    output logic               mark
);

    localparam logic [tlbl_pkg::CNT_W-1:0] POS_V = tlbl_pkg::CNT_W'(POS);

    tlbl_pkg::entry_t entry_reg;
    tlbl_pkg::entry_t entry_next;
    logic             valid_reg;
    logic             valid_next;
    logic             mark_reg;
    logic             mark_next;
    logic             hit;

    assign hit = valid_reg && (entry_reg.pid == ctl.pid)
                 && (!ctl.match_page || (entry_reg.page == ctl.page));

    always_comb
    begin
        entry_next = entry_reg;
        valid_next = valid_reg;
        mark_next  = 1'b0;
        unique case (ctl.cmd)
            tlbl_pkg::CMD_HOLD:
            begin
                mark_next = mark_reg;
            end
            tlbl_pkg::CMD_FLUSH:
            begin
                valid_next = 1'b0;
            end
            tlbl_pkg::CMD_MARK:
            begin
                if (hit)
                begin
                    valid_next = 1'b0;
                    mark_next  = 1'b1;
                end
            end
            tlbl_pkg::CMD_SHIFT:
            begin
                mark_next = next_mark;
                if (!valid_reg)
                begin
                    entry_next = next_entry;
                    valid_next = next_valid;
                end
                else if (!prev_valid)
                begin
                    valid_next = 1'b0;
                end
            end
            tlbl_pkg::CMD_PUSH:
            begin
                entry_next = prev_entry;
                valid_next = prev_valid && !(ctl.trim && (POS_V > ctl.cap_m1));
            end
            default:
            begin
                mark_next = mark_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            mark_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            mark_reg  <= mark_next;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;
    assign valid = valid_reg;
    assign mark  = mark_reg;

endmodule

// ===== design/tlb_lru_process_tagged.sv =====
// Fully associative TLB kept in recency order as a chain of cells, position 0 the most
// recent. Lookups and process exits mark their entries, then a compaction pass moves the
// survivors one cell per cycle towards the front; the pass always runs MAX_ENTRIES steps.
// A lookup passes through the mark, shift, push and response states, a process exit through
// mark, shift and response, a flushing context switch through flush and response, and any
// item that changes nothing goes straight to response. A finished word waits in the output
// register while the next one is taken in; the block only stalls at the end of an item if
// that register is still full. Depends on tlbl_pkg and tlbl_cell.
module tlb_lru_process_tagged #(
    parameter int MAX_ENTRIES = tlbl_pkg::MAX_ENTRIES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [tlbl_pkg::OP_W-1:0]       op,
    input  logic [tlbl_pkg::PID_W-1:0]      process_id,
    input  logic [tlbl_pkg::ADDR_W-1:0]     virtual_address,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic                            tlb_hit,
    output logic                            lru_evicted,
    output logic [tlbl_pkg::CNT_W-1:0]      removed_count,
    output logic [tlbl_pkg::CNT_W-1:0]      occupancy,
    input  logic                            cfg_we,
    input  logic [tlbl_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tlbl_pkg::CFG_W-1:0]      cfg_data
);

    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam logic [IDX_W-1:0] LAST_STEP = IDX_W'(MAX_ENTRIES - 1);
    localparam logic [tlbl_pkg::CNT_W-1:0] CAP_MAX = tlbl_pkg::CNT_W'(MAX_ENTRIES);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_FLUSH = 6'b000010,
        ST_MARK  = 6'b000100,
        ST_SHIFT = 6'b001000,
        ST_PUSH  = 6'b010000,
        ST_RESP  = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    logic [tlbl_pkg::SHIFT_W-1:0] page_shift_reg;
    logic [tlbl_pkg::CNT_W-1:0]   entries_reg;
    logic                         flush_reg;

    logic [tlbl_pkg::OP_W-1:0]    op_reg;
    logic [tlbl_pkg::PID_W-1:0]   pid_reg;
    logic [tlbl_pkg::PAGE_W-1:0]  page_reg;
    logic [IDX_W-1:0]             step_reg;
    logic [tlbl_pkg::CNT_W-1:0]   count_reg;
    logic [tlbl_pkg::CNT_W-1:0]   removed_reg;
    logic                         hit_reg;
    logic                         evict_reg;

    logic                         out_valid_reg;
    logic                         out_hit_reg;
    logic                         out_evict_reg;
    logic [tlbl_pkg::CNT_W-1:0]   out_removed_reg;
    logic [tlbl_pkg::CNT_W-1:0]   out_occ_reg;

    logic [tlbl_pkg::SHIFT_W-1:0] eff_shift;
    logic [tlbl_pkg::CNT_W-1:0]   eff_cap;
    logic [tlbl_pkg::CNT_W-1:0]   removed_sum;
    logic                         accept;
    logic                         pid_ok;
    logic                         out_free;
    logic                         miss_full;
    tlbl_pkg::cell_ctl_t          ctl;

    tlbl_pkg::entry_t             ent [MAX_ENTRIES];
    tlbl_pkg::entry_t             new_entry;
    logic [MAX_ENTRIES-1:0]       vld;
    logic [MAX_ENTRIES-1:0]       mrk;

    assign accept   = in_valid && in_ready;
    assign in_ready = (state_reg == ST_IDLE);
    assign out_free = !out_valid_reg || out_ready;
    assign pid_ok   = (32'(process_id) < 32'(tlbl_pkg::MAX_PROCESSES));

    always_comb
    begin
        eff_shift = page_shift_reg;
        if (page_shift_reg < tlbl_pkg::SHIFT_MIN)
        begin
            eff_shift = tlbl_pkg::SHIFT_MIN;
        end
        else if (page_shift_reg > tlbl_pkg::SHIFT_MAX)
        begin
            eff_shift = tlbl_pkg::SHIFT_MAX;
        end
    end

    always_comb
    begin
        eff_cap = entries_reg;
        if (entries_reg < tlbl_pkg::CAP_MIN)
        begin
            eff_cap = tlbl_pkg::CAP_MIN;
        end
        else if (entries_reg > CAP_MAX)
        begin
            eff_cap = CAP_MAX;
        end
    end

    assign removed_sum = removed_reg + tlbl_pkg::CNT_W'(mrk[0]);
    assign miss_full   = (removed_reg == '0) && (count_reg >= eff_cap);
    assign new_entry   = '{page: page_reg, pid: pid_reg};

    // command broadcast to every cell
    always_comb
    begin
        ctl.cmd        = tlbl_pkg::CMD_HOLD;
        ctl.page       = page_reg;
        ctl.pid        = pid_reg;
        ctl.match_page = (op_reg == tlbl_pkg::OP_LOOKUP);
        ctl.trim       = miss_full;
        ctl.cap_m1     = eff_cap - 1'b1;
        unique case (state_reg)
            ST_FLUSH: ctl.cmd = tlbl_pkg::CMD_FLUSH;
            ST_MARK:  ctl.cmd = tlbl_pkg::CMD_MARK;
            ST_SHIFT: ctl.cmd = tlbl_pkg::CMD_SHIFT;
            ST_PUSH:  ctl.cmd = tlbl_pkg::CMD_PUSH;
            default:  ctl.cmd = tlbl_pkg::CMD_HOLD;
        endcase
    end

    for (genvar i = 0; i < MAX_ENTRIES; i++)
    begin : g_cell
        tlbl_pkg::entry_t prev_e;
        tlbl_pkg::entry_t next_e;
        logic             prev_v;
        logic             next_v;
        logic             next_m;

        if (i == 0)
        begin : g_head
            assign prev_e = new_entry;
            assign prev_v = 1'b1;
        end
        else
        begin : g_body
            assign prev_e = ent[i-1];
            assign prev_v = vld[i-1];
        end

        if (i == MAX_ENTRIES - 1)
        begin : g_tail
            assign next_e = '0;
            assign next_v = 1'b0;
            assign next_m = 1'b0;
        end
        else
        begin : g_inner
            assign next_e = ent[i+1];
            assign next_v = vld[i+1];
            assign next_m = mrk[i+1];
        end

        tlbl_cell #(
            .POS (i)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctl        (ctl),
            .prev_entry (prev_e),
            .prev_valid (prev_v),
            .next_entry (next_e),
            .next_valid (next_v),
            .next_mark  (next_m),
            .entry      (ent[i]),
            .valid      (vld[i]),
            .mark       (mrk[i])
        );
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (!pid_ok)
                    begin
                        state_next = ST_RESP;
                    end
                    else if ((op == tlbl_pkg::OP_LOOKUP) || (op == tlbl_pkg::OP_EXIT))
                    begin
                        state_next = ST_MARK;
                    end
                    else if ((op == tlbl_pkg::OP_SWITCH) && flush_reg)
                    begin
                        state_next = ST_FLUSH;
                    end
                    else
                    begin
                        state_next = ST_RESP;
                    end
                end
            end
            ST_FLUSH: state_next = ST_RESP;
            ST_MARK:  state_next = ST_SHIFT;
            ST_SHIFT:
            begin
                if (step_reg == LAST_STEP)
                begin
                    state_next = (op_reg == tlbl_pkg::OP_LOOKUP) ? ST_PUSH : ST_RESP;
                end
            end
            ST_PUSH:  state_next = ST_RESP;
            ST_RESP:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            page_shift_reg <= tlbl_pkg::PAGE_SHIFT_RST;
            entries_reg    <= tlbl_pkg::ENTRIES_RST;
            flush_reg      <= 1'b0;
            count_reg      <= '0;
            step_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_we)
            begin
                unique case (cfg_index)
                    tlbl_pkg::CFG_PAGE_SHIFT: page_shift_reg <= cfg_data[tlbl_pkg::SHIFT_W-1:0];
                    tlbl_pkg::CFG_ENTRIES:    entries_reg    <= cfg_data;
                    tlbl_pkg::CFG_FLUSH:      flush_reg      <= cfg_data[0];
                    default:                  flush_reg      <= flush_reg;
                endcase
            end

            if (state_reg == ST_MARK)
            begin
                step_reg <= '0;
            end
            else if (state_reg == ST_SHIFT)
            begin
                step_reg <= step_reg + 1'b1;
            end

            if (state_reg == ST_FLUSH)
            begin
                count_reg <= '0;
            end
            else if ((state_reg == ST_SHIFT) && (step_reg == LAST_STEP)
                     && (op_reg == tlbl_pkg::OP_EXIT))
            begin
                count_reg <= count_reg - removed_sum;
            end
            else if ((state_reg == ST_PUSH) && (removed_reg == '0))
            begin
                count_reg <= miss_full ? eff_cap : count_reg + 1'b1;
            end

            if ((state_reg == ST_RESP) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg      <= op;
            pid_reg     <= process_id;
            page_reg    <= tlbl_pkg::PAGE_W'(virtual_address >> eff_shift);
            removed_reg <= '0;
            hit_reg     <= 1'b0;
            evict_reg   <= 1'b0;
        end
        else if (state_reg == ST_FLUSH)
        begin
            removed_reg <= count_reg;
        end
        else if (state_reg == ST_SHIFT)
        begin
            removed_reg <= removed_sum;
        end
        else if (state_reg == ST_PUSH)
        begin
            hit_reg     <= (removed_reg != '0);
            evict_reg   <= miss_full;
            removed_reg <= '0;
        end

        if ((state_reg == ST_RESP) && out_free)
        begin
            out_hit_reg     <= hit_reg;
            out_evict_reg   <= evict_reg;
            out_removed_reg <= removed_reg;
            out_occ_reg     <= count_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign tlb_hit       = out_hit_reg;
    assign lru_evicted   = out_evict_reg;
    assign removed_count = out_removed_reg;
    assign occupancy     = out_occ_reg;

    // occupancy never passes the size of the chain
    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= CAP_MAX)
        else $error("occupancy above chain length");

    // a lookup can only ever find one matching entry
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_SHIFT) && (step_reg == LAST_STEP) && (op_reg == tlbl_pkg::OP_LOOKUP))
        |-> (removed_sum <= tlbl_pkg::CNT_W'(1)))
        else $error("lookup matched more than one entry");

    // between items the valid bits agree with the occupancy count
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> ($countones(vld) == 32'(count_reg)))
        else $error("valid bits disagree with occupancy");

endmodule
